>>> hw/rtl/pwcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcd_pkg - shared types and constants of the pulse-width code decoder
// Command codes, threshold register indexes, reset values and the threshold
// bundle passed from the register file to the decoder.
// ----------------------------------------------------------------------------
package pwcd_pkg;

    // Widths fixed by the interface
    localparam int CFG_W     = 24;
    localparam int ERR_W     = 16;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Parameter defaults
    localparam int FRAME_BITS_DEF = 24;
    localparam int TIME_BITS_DEF  = 24;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE = 2'd0,
        CMD_POLL = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Threshold register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLITCH_MIN  = 3'd0,
        REG_START_MIN   = 3'd1,
        REG_START_MAX   = 3'd2,
        REG_SHORT_MIN   = 3'd3,
        REG_SHORT_MAX   = 3'd4,
        REG_LONG_MIN    = 3'd5,
        REG_LONG_MAX    = 3'd6,
        REG_GAP_TIMEOUT = 3'd7
    } t_reg_idx;

    // Threshold reset values in microseconds
    localparam logic [CFG_W-1:0] GLITCH_MIN_RST  = 24'd100;
    localparam logic [CFG_W-1:0] START_MIN_RST   = 24'd9000;
    localparam logic [CFG_W-1:0] START_MAX_RST   = 24'd15000;
    localparam logic [CFG_W-1:0] SHORT_MIN_RST   = 24'd200;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST   = 24'd700;
    localparam logic [CFG_W-1:0] LONG_MIN_RST    = 24'd800;
    localparam logic [CFG_W-1:0] LONG_MAX_RST    = 24'd1700;
    localparam logic [CFG_W-1:0] GAP_TIMEOUT_RST = 24'd20000;

    // Threshold bundle
    typedef struct packed {
        logic [CFG_W-1:0] glitch_min;
        logic [CFG_W-1:0] start_min;
        logic [CFG_W-1:0] start_max;
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] long_max;
        logic [CFG_W-1:0] gap_timeout;
    } t_cfg;

endpackage

>>> hw/rtl/pwcd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcd_cfg - threshold register file
// Holds the eight timing thresholds, loads them from the write port and
// presents them to the decoder as one bundle.
// ----------------------------------------------------------------------------
module pwcd_cfg
    import pwcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write into the addressed threshold
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GLITCH_MIN:  n_cfg.glitch_min  = i_cfg_data;
                REG_START_MIN:   n_cfg.start_min   = i_cfg_data;
                REG_START_MAX:   n_cfg.start_max   = i_cfg_data;
                REG_SHORT_MIN:   n_cfg.short_min   = i_cfg_data;
                REG_SHORT_MAX:   n_cfg.short_max   = i_cfg_data;
                REG_LONG_MIN:    n_cfg.long_min    = i_cfg_data;
                REG_LONG_MAX:    n_cfg.long_max    = i_cfg_data;
                REG_GAP_TIMEOUT: n_cfg.gap_timeout = i_cfg_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    // Hold thresholds, load defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glitch_min  <= GLITCH_MIN_RST;
            r_cfg.start_min   <= START_MIN_RST;
            r_cfg.start_max   <= START_MAX_RST;
            r_cfg.short_min   <= SHORT_MIN_RST;
            r_cfg.short_max   <= SHORT_MAX_RST;
            r_cfg.long_min    <= LONG_MIN_RST;
            r_cfg.long_max    <= LONG_MAX_RST;
            r_cfg.gap_timeout <= GAP_TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/rf_pulse_width_code_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_pulse_width_code_decoder - pulse-width remote code decoder
// Turns edge timings of a remote's pulse-width code into frames of
// FRAME_BITS bits, with poll and read commands and a bad-pair counter.
// ----------------------------------------------------------------------------
// Each item carries a command, the line level after an edge and the time the
// previous level lasted. One item is taken every clock cycle while o_stall is
// low; it is held in the input register, the whole decoder state update for
// it is done combinationally, and the result register presents its result.
// A stalled result holds the input register, so at most two items are in
// flight. A long low closed by a rising edge starts a frame, each high/low
// pair then shifts in one bit MSB first (short high + long low = 1, long
// high + short low = 0), and frame_done rises once FRAME_BITS bits are in.
// A read returns the frame and clears the decoder; the error count is kept
// until reset. The user must write thresholds only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rf_pulse_width_code_decoder
    import pwcd_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Threshold write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // Item input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic                  i_new_level,
    input  logic [TIME_BITS-1:0]  i_elapsed_us,
    // Result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_frame_done,
    output logic [FRAME_BITS-1:0] o_frame_data,
    output logic                  o_receiving,
    output logic [ERR_W-1:0]      o_error_total
);

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int BR_W  = $clog2(FRAME_BITS + 1);
    localparam logic [BR_W-1:0] FRAME_CNT = BR_W'(FRAME_BITS);

    // Inclusive range check on a common width
    function automatic logic in_window(input logic [CMP_W-1:0] v,
                                       input logic [CMP_W-1:0] lo,
                                       input logic [CMP_W-1:0] hi);
        in_window = (v >= lo) && (v <= hi);
    endfunction

    // Thresholds
    t_cfg w_cfg;

    pwcd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Input register
    logic                 r_in_valid;
    logic [CMD_W-1:0]     r_cmd;
    logic                 r_level;
    logic [TIME_BITS-1:0] r_dt;

    // Decoder state
    logic                  r_recv,  n_recv;
    logic                  r_prev,  n_prev;
    logic [BR_W-1:0]       r_bits,  n_bits;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [TIME_BITS-1:0]  r_htime, n_htime;
    logic [TIME_BITS-1:0]  r_ltime, n_ltime;
    logic                  r_hs,    n_hs;
    logic                  r_ls,    n_ls;
    logic                  r_ready, n_ready;
    logic [ERR_W-1:0]      r_err,   n_err;
    logic [FRAME_BITS-1:0] n_data_out;

    // Result register
    logic                  r_out_valid;
    logic                  r_out_ready;
    logic [FRAME_BITS-1:0] r_out_data;
    logic                  r_out_recv;
    logic [ERR_W-1:0]      r_out_err;

    logic w_adv;
    logic w_in_take;

    // Handshake: process the held item when the result slot is free
    assign w_adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_adv;
    assign w_in_take = i_valid && !o_stall;

    // Next decoder state for the held item
    always_comb begin
        logic [CMP_W-1:0] dt_x;
        logic             pair_one;
        logic             pair_zero;
        logic             do_clear;

        n_recv  = r_recv;
        n_prev  = r_prev;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_htime = r_htime;
        n_ltime = r_ltime;
        n_hs    = r_hs;
        n_ls    = r_ls;
        n_ready = r_ready;
        n_err   = r_err;
        dt_x      = CMP_W'(r_dt);
        pair_one  = 1'b0;
        pair_zero = 1'b0;
        do_clear  = 1'b0;
        n_data_out = r_shift;

        unique case (t_cmd'(r_cmd))
            CMD_EDGE: begin
                if (dt_x < CMP_W'(w_cfg.glitch_min)) begin
                    n_prev = r_level;
                end else begin
                    // Abort a stalled frame before anything else
                    if (n_recv && (dt_x > CMP_W'(w_cfg.gap_timeout))) begin
                        n_recv  = 1'b0;
                        n_bits  = '0;
                        n_shift = '0;
                        n_htime = '0;
                        n_ltime = '0;
                        n_hs    = 1'b0;
                        n_ls    = 1'b0;
                        n_ready = 1'b0;
                    end
                    if (!n_recv) begin
                        // Look for a start: long low ended by a rising edge
                        if (!r_prev && r_level &&
                            in_window(dt_x, CMP_W'(w_cfg.start_min),
                                      CMP_W'(w_cfg.start_max))) begin
                            n_recv  = 1'b1;
                            n_bits  = '0;
                            n_shift = '0;
                            n_hs    = 1'b0;
                            n_ls    = 1'b0;
                        end
                    end else begin
                        // Record the half of the pair that just ended
                        if (r_prev) begin
                            n_htime = r_dt;
                            n_hs    = 1'b1;
                        end else if ((n_bits != '0) || n_hs) begin
                            n_ltime = r_dt;
                            n_ls    = 1'b1;
                        end
                        if (n_hs && n_ls) begin
                            pair_one  = in_window(CMP_W'(n_htime),
                                                  CMP_W'(w_cfg.short_min),
                                                  CMP_W'(w_cfg.short_max)) &&
                                        in_window(CMP_W'(n_ltime),
                                                  CMP_W'(w_cfg.long_min),
                                                  CMP_W'(w_cfg.long_max));
                            pair_zero = in_window(CMP_W'(n_htime),
                                                  CMP_W'(w_cfg.long_min),
                                                  CMP_W'(w_cfg.long_max)) &&
                                        in_window(CMP_W'(n_ltime),
                                                  CMP_W'(w_cfg.short_min),
                                                  CMP_W'(w_cfg.short_max));
                            if (!pair_one && !pair_zero) begin
                                // Bad pair: count it and drop the frame
                                n_err   = r_err + ERR_W'(1);
                                n_recv  = 1'b0;
                                n_bits  = '0;
                                n_shift = '0;
                                n_htime = '0;
                                n_ltime = '0;
                                n_hs    = 1'b0;
                                n_ls    = 1'b0;
                                n_ready = 1'b0;
                            end else begin
                                n_shift = (n_shift << 1) | FRAME_BITS'(pair_one);
                                n_bits  = n_bits + BR_W'(1);
                                n_hs    = 1'b0;
                                n_ls    = 1'b0;
                                n_htime = '0;
                                n_ltime = '0;
                                if (n_bits >= FRAME_CNT) begin
                                    n_ready = 1'b1;
                                    n_recv  = 1'b0;
                                end
                            end
                        end
                    end
                    n_prev = r_level;
                end
                n_data_out = n_shift;
            end
            CMD_POLL: begin
                do_clear   = !r_ready && r_recv &&
                             (dt_x > CMP_W'(w_cfg.gap_timeout));
                n_data_out = do_clear ? '0 : r_shift;
            end
            CMD_READ: begin
                do_clear   = 1'b1;
                n_data_out = r_shift;
            end
            CMD_NONE: begin
                n_data_out = r_shift;
            end
            default: begin
                n_data_out = r_shift;
            end
        endcase

        // Decoder clear for poll timeout and read
        if (do_clear) begin
            n_recv  = 1'b0;
            n_bits  = '0;
            n_shift = '0;
            n_htime = '0;
            n_ltime = '0;
            n_hs    = 1'b0;
            n_ls    = 1'b0;
            n_ready = 1'b0;
        end
    end

    // Capture items into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd   <= i_cmd;
            r_level <= i_new_level;
            r_dt    <= i_elapsed_us;
        end
    end

    // Advance decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv  <= 1'b0;
            r_prev  <= 1'b0;
            r_bits  <= '0;
            r_shift <= '0;
            r_htime <= '0;
            r_ltime <= '0;
            r_hs    <= 1'b0;
            r_ls    <= 1'b0;
            r_ready <= 1'b0;
            r_err   <= '0;
        end else if (w_adv) begin
            r_recv  <= n_recv;
            r_prev  <= n_prev;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_htime <= n_htime;
            r_ltime <= n_ltime;
            r_hs    <= n_hs;
            r_ls    <= n_ls;
            r_ready <= n_ready;
            r_err   <= n_err;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ready <= n_ready;
            r_out_data  <= n_data_out;
            r_out_recv  <= n_recv;
            r_out_err   <= n_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_done  = r_out_ready;
    assign o_frame_data  = r_out_data;
    assign o_receiving   = r_out_recv;
    assign o_error_total = r_out_err;

    // Checks
    a_bits_below_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recv |-> (r_bits < FRAME_CNT))
        else $error("bit count reached frame length while receiving");

    a_no_complete_pair_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_hs && r_ls))
        else $error("complete high/low pair left undecoded");

    a_err_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_err))
        else $error("error count changed without an item");

endmodule
